// ===== rtl/core/cascaded_prescaled_timer_bank_assert.svh =====
// Assertion macros for the timer bank.
`ifndef CASCADED_PRESCALED_TIMER_BANK_ASSERT_SVH
`define CASCADED_PRESCALED_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CPT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer bank check failed");

// Next-cycle implication, checked out of reset
`define CPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer bank check failed");

`endif

// ===== rtl/core/cpt_pkg.sv =====
`default_nettype none

package cpt_pkg;

   // Field widths
   localparam int MODE_W   = 3;
   localparam int INDEX_W  = 2;
   localparam int DATA_W   = 16;
   localparam int CYCLE_W  = 10;
   localparam int MASK_W   = 4;

   // Bank size
   localparam int NUM_TIMERS_DEF = 4;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_RELOAD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WR_CONTROL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RD_COUNT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RD_CONTROL = 3'd4;

   // Control word bit positions
   localparam int CTL_ENABLE_BIT  = 7;
   localparam int CTL_IRQ_BIT     = 6;
   localparam int CTL_CASCADE_BIT = 2;

   // Prescaler select codes
   localparam logic [1:0] PSC_DIV1    = 2'd0;
   localparam logic [1:0] PSC_DIV64   = 2'd1;
   localparam logic [1:0] PSC_DIV256  = 2'd2;
   localparam logic [1:0] PSC_DIV1024 = 2'd3;

   localparam logic [DATA_W-1:0] COUNT_MAX = 16'hFFFF;

   // True when the cycle count is a multiple of the selected prescaler
   function automatic logic prescale_hit(input logic [1:0] sel,
                                         input logic [CYCLE_W-1:0] cycle);
      logic hit;
      hit = 1'b0;
      case (sel)
         PSC_DIV1:    hit = 1'b1;
         PSC_DIV64:   hit = (cycle[5:0] == 6'd0);
         PSC_DIV256:  hit = (cycle[7:0] == 8'd0);
         PSC_DIV1024: hit = (cycle == 10'd0);
         default:     hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cascaded_prescaled_timer_bank.sv =====
// Words pass the input register, then the result register. The tick cascade through all timers
// is one combinational pass. Throughput: one word per cycle while rsp_stall stays low.
// Response stall back-pressures the request side only when both registers are full.
// Reset (synchronous, active high): counters, reloads and controls clear to zero,
// all timers disabled, both pipeline registers empty.
`default_nettype none

`include "cascaded_prescaled_timer_bank_assert.svh"

module cascaded_prescaled_timer_bank #(
   parameter int NUM_TIMERS = cpt_pkg::NUM_TIMERS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [cpt_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [cpt_pkg::INDEX_W-1:0]  req_timer_index,
   input  wire logic [cpt_pkg::DATA_W-1:0]   req_write_data,
   input  wire logic [cpt_pkg::CYCLE_W-1:0]  req_cycle_low,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [cpt_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [cpt_pkg::MASK_W-1:0]        rsp_overflow_mask,
   output logic [cpt_pkg::MASK_W-1:0]        rsp_irq_mask
);

   // Input register
   logic                             s1_valid_ff, s1_valid_in;
   logic [cpt_pkg::MODE_W-1:0]       s1_mode_ff;
   logic [cpt_pkg::INDEX_W-1:0]      s1_index_ff;
   logic [cpt_pkg::DATA_W-1:0]       s1_data_ff;
   logic [cpt_pkg::CYCLE_W-1:0]      s1_cycle_ff;

   // Timer state
   logic [cpt_pkg::DATA_W-1:0] count_ff   [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0] count_in   [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0] reload_ff  [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0] reload_in  [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0] control_ff [NUM_TIMERS];
   logic [cpt_pkg::DATA_W-1:0] control_in [NUM_TIMERS];

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [cpt_pkg::DATA_W-1:0]       rsp_read_data_ff, rsp_read_data_in;
   logic [cpt_pkg::MASK_W-1:0]       rsp_ovf_ff, rsp_ovf_in;
   logic [cpt_pkg::MASK_W-1:0]       rsp_irq_ff, rsp_irq_in;

   logic out_free;
   logic fire;
   logic req_accept;

   // Handshake: the stored word moves on whenever the result register can take it
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? fire : rsp_valid_ff;

   // Item execution: tick cascade, register writes and reads
   always_comb begin
      logic is_tick, is_wr_reload, is_wr_ctl, is_rd_cnt, is_rd_ctl;
      logic prev_ovf;
      logic sel, en, step, wrap;
      logic [cpt_pkg::DATA_W-1:0] ctl;

      is_tick      = 1'b0;
      is_wr_reload = 1'b0;
      is_wr_ctl    = 1'b0;
      is_rd_cnt    = 1'b0;
      is_rd_ctl    = 1'b0;
      case (s1_mode_ff)
         cpt_pkg::MODE_TICK:       is_tick      = 1'b1;
         cpt_pkg::MODE_WR_RELOAD:  is_wr_reload = 1'b1;
         cpt_pkg::MODE_WR_CONTROL: is_wr_ctl    = 1'b1;
         cpt_pkg::MODE_RD_COUNT:   is_rd_cnt    = 1'b1;
         cpt_pkg::MODE_RD_CONTROL: is_rd_ctl    = 1'b1;
         default: ;
      endcase

      prev_ovf         = 1'b0;
      rsp_read_data_in = '0;
      rsp_ovf_in       = '0;
      rsp_irq_in       = '0;

      for (int i = 0; i < NUM_TIMERS; i++) begin
         ctl  = control_ff[i];
         sel  = (s1_index_ff == cpt_pkg::INDEX_W'(i));
         en   = ctl[cpt_pkg::CTL_ENABLE_BIT];
         if (ctl[cpt_pkg::CTL_CASCADE_BIT] && (i > 0)) begin
            step = en && prev_ovf;
         end else begin
            step = en && cpt_pkg::prescale_hit(ctl[1:0], s1_cycle_ff);
         end
         step = step && is_tick;
         wrap = step && (count_ff[i] == cpt_pkg::COUNT_MAX);

         count_in[i]   = count_ff[i];
         reload_in[i]  = reload_ff[i];
         control_in[i] = control_ff[i];

         // counting
         if (step) begin
            count_in[i] = wrap ? reload_ff[i] : 16'(count_ff[i] + 16'd1);
         end
         // register writes
         if (is_wr_reload && sel) begin
            reload_in[i] = s1_data_ff;
         end
         if (is_wr_ctl && sel) begin
            if (!en && s1_data_ff[cpt_pkg::CTL_ENABLE_BIT]) begin
               count_in[i] = reload_ff[i];
            end
            control_in[i] = s1_data_ff;
         end
         // reads
         if (is_rd_cnt && sel) begin
            rsp_read_data_in = rsp_read_data_in | count_ff[i];
         end
         if (is_rd_ctl && sel) begin
            rsp_read_data_in = rsp_read_data_in | control_ff[i];
         end

         rsp_ovf_in[i] = wrap;
         rsp_irq_in[i] = wrap && ctl[cpt_pkg::CTL_IRQ_BIT];
         prev_ovf      = wrap;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Timer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_ff[i]   <= '0;
            reload_ff[i]  <= '0;
            control_ff[i] <= '0;
         end
      end else if (fire) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            count_ff[i]   <= count_in[i];
            reload_ff[i]  <= reload_in[i];
            control_ff[i] <= control_in[i];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff  <= req_mode;
         s1_index_ff <= req_timer_index;
         s1_data_ff  <= req_write_data;
         s1_cycle_ff <= req_cycle_low;
      end
      if (fire) begin
         rsp_read_data_ff <= rsp_read_data_in;
         rsp_ovf_ff       <= rsp_ovf_in;
         rsp_irq_ff       <= rsp_irq_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_overflow_mask = rsp_ovf_ff;
   assign rsp_irq_mask      = rsp_irq_ff;

   // Checks
   `CPT_ASSERT_IMPLIES(a_irq_within_ovf, clock, reset, rsp_valid_ff,
                       (rsp_irq_ff & ~rsp_ovf_ff) == '0)
   `CPT_ASSERT_IMPLIES(a_read_no_masks, clock, reset,
                       rsp_valid_ff && (rsp_read_data_ff != '0),
                       (rsp_ovf_ff == '0) && (rsp_irq_ff == '0))
   `CPT_ASSERT_NEXT(a_held_word_stays, clock, reset, s1_valid_ff && !out_free, s1_valid_ff)
   `CPT_ASSERT_IMPLIES(a_stall_only_full, clock, reset, !s1_valid_ff, !req_stall)

endmodule

`default_nettype wire

// ===== bench/cascaded_prescaled_timer_bank_tb.sv =====
`timescale 1ns / 1ps

module cascaded_prescaled_timer_bank_tb;

   localparam int NT           = cpt_pkg::NUM_TIMERS_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLDOFF_LEN  = 300;
   localparam int PHASE_WORDS  = 385;

   // modes the block must ignore
   localparam logic [cpt_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [cpt_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [cpt_pkg::DATA_W-1:0] read_data;
      logic [cpt_pkg::MASK_W-1:0] overflow_mask;
      logic [cpt_pkg::MASK_W-1:0] irq_mask;
   } timer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [cpt_pkg::MODE_W-1:0]  req_mode = '0;
   logic [cpt_pkg::INDEX_W-1:0] req_timer_index = '0;
   logic [cpt_pkg::DATA_W-1:0]  req_write_data = '0;
   logic [cpt_pkg::CYCLE_W-1:0] req_cycle_low = '0;

   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [cpt_pkg::DATA_W-1:0]  rsp_read_data;
   logic [cpt_pkg::MASK_W-1:0]  rsp_overflow_mask;
   logic [cpt_pkg::MASK_W-1:0]  rsp_irq_mask;

   // shadow copy of the timer registers
   logic [cpt_pkg::DATA_W-1:0] count_shadow   [NT] = '{default: '0};
   logic [cpt_pkg::DATA_W-1:0] reload_shadow  [NT] = '{default: '0};
   logic [cpt_pkg::DATA_W-1:0] control_shadow [NT] = '{default: '0};

   timer_result_type timer_results_due[$];

   int   idle_pct_send  = 0;
   int   idle_pct_stall = 0;
   logic holdoff_go     = 1'b0;
   logic holdoff_taken  = 1'b0;
   int   holdoff_left   = 0;
   int   fail_count     = 0;
   int   words_sent     = 0;
   int   ticks_sent     = 0;
   int   results_seen   = 0;
   int   overflows_seen = 0;
   int   irqs_seen      = 0;
   int   clocks_run     = 0;

   cascaded_prescaled_timer_bank dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_timer_index   (req_timer_index),
      .req_write_data    (req_write_data),
      .req_cycle_low     (req_cycle_low),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_overflow_mask (rsp_overflow_mask),
      .rsp_irq_mask      (rsp_irq_mask)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      clocks_run <= clocks_run + 1;
      if (clocks_run >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, timer_results_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall: one long hold-off on request, else random
   always @(negedge clock) begin
      if (holdoff_go && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         rsp_stall <= 1'b1;
         holdoff_left <= HOLDOFF_LEN - 1;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct_stall);
      end
   end

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (rsp_overflow_mask != '0) overflows_seen <= overflows_seen + 1;
         if (rsp_irq_mask != '0) irqs_seen <= irqs_seen + 1;
         if (timer_results_due.size() == 0) begin
            $display("%0t: unexpected result word rd=%h ovf=%h irq=%h", $time,
                     rsp_read_data, rsp_overflow_mask, rsp_irq_mask);
            fail_count = fail_count + 1;
         end else begin
            want = timer_results_due.pop_front();
            if (rsp_read_data != want.read_data) begin
               $display("%0t: read_data expected %h got %h", $time,
                        want.read_data, rsp_read_data);
               fail_count = fail_count + 1;
            end
            if (rsp_overflow_mask != want.overflow_mask) begin
               $display("%0t: overflow_mask expected %h got %h", $time,
                        want.overflow_mask, rsp_overflow_mask);
               fail_count = fail_count + 1;
            end
            if (rsp_irq_mask != want.irq_mask) begin
               $display("%0t: irq_mask expected %h got %h", $time,
                        want.irq_mask, rsp_irq_mask);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   // true when the cycle count lands on the selected prescaler period
   function automatic logic divider_hit(input logic [1:0] sel,
                                        input logic [cpt_pkg::CYCLE_W-1:0] cyc);
      logic [cpt_pkg::CYCLE_W-1:0] low_bits;
      case (sel)
         cpt_pkg::PSC_DIV1:   low_bits = 10'h000;
         cpt_pkg::PSC_DIV64:  low_bits = 10'h03F;
         cpt_pkg::PSC_DIV256: low_bits = 10'h0FF;
         default:             low_bits = 10'h3FF;
      endcase
      return (cyc & low_bits) == '0;
   endfunction

   function automatic logic [cpt_pkg::DATA_W-1:0] control_bits(input logic en, input logic irq,
                                                               input logic casc,
                                                               input logic [1:0] psc);
      logic [cpt_pkg::DATA_W-1:0] w;
      w = '0;
      w[1:0] = psc;
      w[cpt_pkg::CTL_ENABLE_BIT] = en;
      w[cpt_pkg::CTL_IRQ_BIT] = irq;
      w[cpt_pkg::CTL_CASCADE_BIT] = casc;
      return w;
   endfunction

   // apply one accepted word to the shadow registers and queue its result
   task automatic step_timer_bank(input logic [cpt_pkg::MODE_W-1:0] mode,
                                  input logic [cpt_pkg::INDEX_W-1:0] idx,
                                  input logic [cpt_pkg::DATA_W-1:0] data,
                                  input logic [cpt_pkg::CYCLE_W-1:0] cyc);
      timer_result_type r;
      logic carry;
      logic wrapped;
      logic bump;
      logic [cpt_pkg::DATA_W-1:0] ctl;
      r = '0;
      case (mode)
         cpt_pkg::MODE_TICK: begin
            carry = 1'b0;
            for (int i = 0; i < NT; i++) begin
               ctl = control_shadow[i];
               wrapped = 1'b0;
               if (ctl[cpt_pkg::CTL_ENABLE_BIT]) begin
                  if (ctl[cpt_pkg::CTL_CASCADE_BIT] && i > 0) bump = carry;
                  else bump = divider_hit(ctl[1:0], cyc);
                  if (bump) begin
                     if (count_shadow[i] == cpt_pkg::COUNT_MAX) begin
                        count_shadow[i] = reload_shadow[i];
                        wrapped = 1'b1;
                        r.overflow_mask[i] = 1'b1;
                        if (ctl[cpt_pkg::CTL_IRQ_BIT]) r.irq_mask[i] = 1'b1;
                     end else begin
                        count_shadow[i] = count_shadow[i] + 16'd1;
                     end
                  end
               end
               carry = wrapped;
            end
         end
         cpt_pkg::MODE_WR_RELOAD: begin
            if (idx < NT) reload_shadow[idx] = data;
         end
         cpt_pkg::MODE_WR_CONTROL: begin
            if (idx < NT) begin
               // enable going high reloads the counter
               if (!control_shadow[idx][cpt_pkg::CTL_ENABLE_BIT] && data[cpt_pkg::CTL_ENABLE_BIT])
                  count_shadow[idx] = reload_shadow[idx];
               control_shadow[idx] = data;
            end
         end
         cpt_pkg::MODE_RD_COUNT: begin
            if (idx < NT) r.read_data = count_shadow[idx];
         end
         cpt_pkg::MODE_RD_CONTROL: begin
            if (idx < NT) r.read_data = control_shadow[idx];
         end
         default: ;
      endcase
      timer_results_due.push_back(r);
   endtask

   // offer one word, hold it until accepted, then predict
   task automatic send_word(input logic [cpt_pkg::MODE_W-1:0] mode,
                            input logic [cpt_pkg::INDEX_W-1:0] idx,
                            input logic [cpt_pkg::DATA_W-1:0] data,
                            input logic [cpt_pkg::CYCLE_W-1:0] cyc);
      while ($urandom_range(99) < idle_pct_send) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_timer_index <= idx;
      req_write_data <= data;
      req_cycle_low <= cyc;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      words_sent++;
      if (mode == cpt_pkg::MODE_TICK) ticks_sent++;
      step_timer_bank(mode, idx, data, cyc);
   endtask

   // cycle counts biased toward prescaler boundaries
   function automatic logic [cpt_pkg::CYCLE_W-1:0] pick_cycle();
      case ($urandom_range(3))
         0: return '0;
         1: return cpt_pkg::CYCLE_W'($urandom_range(15) << 6);
         2: return cpt_pkg::CYCLE_W'($urandom_range(3) << 8);
         default: return cpt_pkg::CYCLE_W'($urandom_range(1023));
      endcase
   endfunction

   // reloads mostly close to the top so overflows come often
   function automatic logic [cpt_pkg::DATA_W-1:0] pick_reload();
      case ($urandom_range(3))
         0, 1: return 16'hFFF0 | cpt_pkg::DATA_W'($urandom_range(15));
         2: return 16'hFF00 | cpt_pkg::DATA_W'($urandom_range(255));
         default: return cpt_pkg::DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [cpt_pkg::MODE_W-1:0] MODE_WORD_JUNK();
      return cpt_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
   endfunction

   task automatic test_reset_readback();
      send_word(cpt_pkg::MODE_RD_COUNT, 2'd0, 16'h0000, '0);
      send_word(cpt_pkg::MODE_RD_CONTROL, 2'd3, 16'hFFFF, 10'h3FF);
   endtask

   // unused modes with every other field at its top value
   task automatic test_unused_modes();
      for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
         send_word(m[cpt_pkg::MODE_W-1:0], 2'd3, 16'hFFFF, 10'h3FF);
   endtask

   // enable rising loads reload; a later reload write leaves the counter alone
   task automatic test_enable_loads_reload();
      send_word(cpt_pkg::MODE_WR_RELOAD, 2'd0, 16'hFFFE, '0);
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd0,
                control_bits(1'b1, 1'b1, 1'b0, cpt_pkg::PSC_DIV1), '0);
      send_word(cpt_pkg::MODE_WR_RELOAD, 2'd0, 16'h1234, '0);
      send_word(cpt_pkg::MODE_RD_COUNT, 2'd0, '0, '0);
   endtask

   // timer 0 wraps and timer 1 follows through the cascade in the same tick
   task automatic test_cascade_overflow();
      send_word(cpt_pkg::MODE_WR_RELOAD, 2'd1, 16'hFFFF, '0);
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd1,
                control_bits(1'b1, 1'b1, 1'b1, cpt_pkg::PSC_DIV1024), '0);
      send_word(cpt_pkg::MODE_TICK, 2'd0, '0, 10'h3FF);
      send_word(cpt_pkg::MODE_TICK, 2'd0, '0, 10'h3FF);
   endtask

   // cascade bit ignored on timer 0; cascade from a disabled timer never counts
   task automatic test_cascade_rules();
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd0,
                control_bits(1'b1, 1'b0, 1'b1, cpt_pkg::PSC_DIV1024), '0);
      send_word(cpt_pkg::MODE_TICK, 2'd0, '0, 10'h001);
      send_word(cpt_pkg::MODE_TICK, 2'd0, '0, 10'h000);
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd1, 16'h0000, '0);
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd2,
                control_bits(1'b1, 1'b1, 1'b1, cpt_pkg::PSC_DIV1), '0);
      send_word(cpt_pkg::MODE_TICK, 2'd0, '0, 10'h000);
   endtask

   // spare control bits are stored and read back
   task automatic test_control_all_ones();
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd3, 16'hFFFF, '0);
      send_word(cpt_pkg::MODE_RD_CONTROL, 2'd3, '0, '0);
      send_word(cpt_pkg::MODE_RD_COUNT, 2'd2, '0, '0);
   endtask

   // mostly ticks over enabled timers, with register traffic and some junk
   task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
      int pick;
      logic [cpt_pkg::INDEX_W-1:0] idx;
      logic [cpt_pkg::DATA_W-1:0] data;
      idle_pct_send = send_pct;
      idle_pct_stall = stall_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         idx = cpt_pkg::INDEX_W'($urandom_range(3));
         data = cpt_pkg::DATA_W'($urandom);
         if (pick < 55) begin
            send_word(cpt_pkg::MODE_TICK, idx, data, pick_cycle());
         end else if (pick < 65) begin
            send_word(cpt_pkg::MODE_WR_RELOAD, idx, pick_reload(), pick_cycle());
         end else if (pick < 77) begin
            data[cpt_pkg::CTL_ENABLE_BIT] = ($urandom_range(3) != 0);
            send_word(cpt_pkg::MODE_WR_CONTROL, idx, data, pick_cycle());
         end else if (pick < 85) begin
            send_word(cpt_pkg::MODE_RD_COUNT, idx, data, pick_cycle());
         end else if (pick < 93) begin
            send_word(cpt_pkg::MODE_RD_CONTROL, idx, data, pick_cycle());
         end else begin
            send_word(MODE_WORD_JUNK(), idx, data, cpt_pkg::CYCLE_W'($urandom_range(1023)));
         end
      end
   endtask

   // output held off for a long stretch while ticks keep coming
   task automatic test_output_holdoff();
      idle_pct_send = 0;
      idle_pct_stall = 0;
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd0, 16'h0000, '0);
      send_word(cpt_pkg::MODE_WR_RELOAD, 2'd0, 16'hFFFA, '0);
      send_word(cpt_pkg::MODE_WR_CONTROL, 2'd0,
                control_bits(1'b1, 1'b1, 1'b0, cpt_pkg::PSC_DIV1), '0);
      holdoff_go = 1'b1;
      for (int n = 0; n < 20; n++)
         send_word(cpt_pkg::MODE_TICK, 2'd0, '0, cpt_pkg::CYCLE_W'(n));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_readback();
      test_unused_modes();
      test_enable_loads_reload();
      test_cascade_overflow();
      test_cascade_rules();
      test_control_all_ones();

      test_random_traffic(PHASE_WORDS, 0, 0);
      test_random_traffic(PHASE_WORDS, 74, 0);
      test_random_traffic(PHASE_WORDS, 0, 74);
      test_random_traffic(PHASE_WORDS, 28, 28);
      test_output_holdoff();

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      idle_pct_stall = 0;
      while (timer_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d words (%0d ticks) sent, %0d results checked, %0d mismatches",
               words_sent, ticks_sent, results_seen, fail_count);
      $display("Summary: %0d overflow, %0d interrupt results, idle phases, %0d-cycle hold-off",
               overflows_seen, irqs_seen, HOLDOFF_LEN);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
